### rtl/bgd_pkg.sv
package bgd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW    = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS   = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLICK_MS      = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_MS = 8'd3;

  // Register reset values
  localparam logic        RST_ACTIVE_LOW    = 1'b1;
  localparam logic [7:0]  RST_DEBOUNCE_MS   = 8'd50;
  localparam logic [15:0] RST_CLICK_MS      = 16'd400;
  localparam logic [15:0] RST_LONG_PRESS_MS = 16'd1000;

  // Gesture state machine, one-hot
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PRESSED  = 4'b0010,
    ST_RELEASED = 4'b0100,
    ST_SECOND   = 4'b1000
  } gesture_state_e;

  // Poll word
  typedef struct packed {
    logic        button_level;
    logic [31:0] time_now_ms;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic press_event;
    logic release_event;
    logic long_start_event;
    logic long_end_event;
    logic click_event;
    logic double_click_event;
    logic pressed_now;
    logic long_pressed_now;
  } out_word_t;

endpackage

### rtl/button_gesture_detector.sv
// An accepted poll word passes through the input register, then the result register, to its result word.
// Throughput: one poll word per cycle unless the result channel stalls; the state update is a single pass of 32-bit
// subtract-and-compare logic between the input register and the result register.
// Reset (rst_ni, asynchronous, active low): state idle, flags and stamps cleared,
// registers back to active_low 1, debounce 50, click 400, long press 1000; no words held.
module button_gesture_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // poll channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bgd_pkg::in_word_t                in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bgd_pkg::out_word_t               out_data_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bgd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bgd_pkg::CfgDataW-1:0]     cfg_data_i
);

  // configuration registers
  logic        active_low_q;
  logic [7:0]  debounce_q;
  logic [15:0] click_q;
  logic [15:0] long_press_q;

  // input stage
  logic              in_valid_q;
  bgd_pkg::in_word_t in_q;

  // gesture state
  bgd_pkg::gesture_state_e state_q, state_d;
  logic        long_flag_q, long_flag_d;
  logic        reported_q, reported_d;
  logic [31:0] press_stamp_q, press_stamp_d;
  logic [31:0] release_stamp_q, release_stamp_d;

  // result stage
  logic               out_valid_q;
  bgd_pkg::out_word_t out_q, out_d;

  logic advance;
  logic down;
  logic [31:0] held;
  logic [31:0] since_rel;
  logic held_gt_deb, held_gt_long, held_gt_click, rel_gt_deb;

  assign cfg_ready_o = 1'b1;

  // word moves on when the result slot is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= bgd_pkg::RST_ACTIVE_LOW;
      debounce_q   <= bgd_pkg::RST_DEBOUNCE_MS;
      click_q      <= bgd_pkg::RST_CLICK_MS;
      long_press_q <= bgd_pkg::RST_LONG_PRESS_MS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bgd_pkg::CFG_ACTIVE_LOW:    active_low_q <= cfg_data_i[0];
        bgd_pkg::CFG_DEBOUNCE_MS:   debounce_q   <= cfg_data_i[7:0];
        bgd_pkg::CFG_CLICK_MS:      click_q      <= cfg_data_i;
        bgd_pkg::CFG_LONG_PRESS_MS: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // wrapping elapsed times and threshold compares
  assign down          = (in_q.button_level != active_low_q);
  assign held          = in_q.time_now_ms - press_stamp_q;
  assign since_rel     = in_q.time_now_ms - release_stamp_q;
  assign held_gt_deb   = held > {24'd0, debounce_q};
  assign held_gt_long  = held > {16'd0, long_press_q};
  assign held_gt_click = held > {16'd0, click_q};
  assign rel_gt_deb    = since_rel > {24'd0, debounce_q};

  // next state and events
  always_comb begin
    state_d         = state_q;
    long_flag_d     = long_flag_q;
    reported_d      = reported_q;
    press_stamp_d   = press_stamp_q;
    release_stamp_d = release_stamp_q;
    out_d           = '0;
    unique case (state_q)
      bgd_pkg::ST_IDLE: begin
        if (down) begin
          state_d       = bgd_pkg::ST_PRESSED;
          press_stamp_d = in_q.time_now_ms;
        end
      end
      bgd_pkg::ST_PRESSED: begin
        if (down) begin
          if (held_gt_deb && !reported_q) begin
            reported_d        = 1'b1;
            out_d.press_event = 1'b1;
          end
          if (held_gt_long && !long_flag_q) begin
            long_flag_d            = 1'b1;
            out_d.long_start_event = 1'b1;
          end
        end else begin
          // short bounce drops back to idle silently
          if (!held_gt_deb) begin
            state_d = bgd_pkg::ST_IDLE;
          end else begin
            state_d             = bgd_pkg::ST_RELEASED;
            reported_d          = 1'b0;
            out_d.release_event = 1'b1;
          end
          release_stamp_d = in_q.time_now_ms;
        end
      end
      bgd_pkg::ST_RELEASED: begin
        // new press beats long-end timeout, which beats click timeout
        priority if (down && rel_gt_deb) begin
          press_stamp_d = in_q.time_now_ms;
          state_d       = bgd_pkg::ST_SECOND;
        end else if (held_gt_long) begin
          long_flag_d          = 1'b0;
          state_d              = bgd_pkg::ST_IDLE;
          out_d.long_end_event = 1'b1;
        end else if (held_gt_click) begin
          state_d           = bgd_pkg::ST_IDLE;
          out_d.click_event = 1'b1;
        end
      end
      bgd_pkg::ST_SECOND: begin
        if (!down && held_gt_deb) begin
          state_d                  = bgd_pkg::ST_IDLE;
          out_d.double_click_event = 1'b1;
        end
      end
      default: begin
        state_d = bgd_pkg::ST_IDLE;
      end
    endcase
    out_d.pressed_now      = (state_d == bgd_pkg::ST_PRESSED);
    out_d.long_pressed_now = (state_d == bgd_pkg::ST_PRESSED) && long_flag_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= bgd_pkg::ST_IDLE;
      long_flag_q     <= 1'b0;
      reported_q      <= 1'b0;
      press_stamp_q   <= '0;
      release_stamp_q <= '0;
    end else if (advance) begin
      state_q         <= state_d;
      long_flag_q     <= long_flag_d;
      reported_q      <= reported_d;
      press_stamp_q   <= press_stamp_d;
      release_stamp_q <= release_stamp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("gesture state not one-hot");

  a_long_implies_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.long_pressed_now |-> out_q.pressed_now)
    else $error("long-pressed status without pressed status");

  a_release_not_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.release_event |-> !out_q.pressed_now)
    else $error("release event while still pressed");

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word lost before result register");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked word");

endmodule

### sim/tb_button_gesture_detector.sv
`timescale 1ns / 1ps

module tb_button_gesture_detector;

  // Predicts the gesture machine word by word and holds the results still owed
  class gesture_scoreboard;
    logic        active_low;
    logic [7:0]  debounce_ms;
    logic [15:0] click_ms;
    logic [15:0] long_ms;

    bgd_pkg::gesture_state_e st;
    logic        long_flag;
    logic        press_reported;
    logic [31:0] press_stamp;
    logic [31:0] release_stamp;

    bgd_pkg::out_word_t expected_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      active_low     = bgd_pkg::RST_ACTIVE_LOW;
      debounce_ms    = bgd_pkg::RST_DEBOUNCE_MS;
      click_ms       = bgd_pkg::RST_CLICK_MS;
      long_ms        = bgd_pkg::RST_LONG_PRESS_MS;
      st             = bgd_pkg::ST_IDLE;
      long_flag      = 1'b0;
      press_reported = 1'b0;
      press_stamp    = '0;
      release_stamp  = '0;
      errors         = 0;
      checked        = 0;
    endfunction

    // Register write as accepted by the block; unknown indexes are dropped
    function void set_reg(logic [bgd_pkg::CfgIdxW-1:0] idx,
                          logic [bgd_pkg::CfgDataW-1:0] val);
      case (idx)
        bgd_pkg::CFG_ACTIVE_LOW:    active_low  = val[0];
        bgd_pkg::CFG_DEBOUNCE_MS:   debounce_ms = val[7:0];
        bgd_pkg::CFG_CLICK_MS:      click_ms    = val;
        bgd_pkg::CFG_LONG_PRESS_MS: long_ms     = val;
        default: ;
      endcase
    endfunction

    // One poll word: advance the machine and queue the result it owes
    function void note_poll(bgd_pkg::in_word_t w);
      bgd_pkg::out_word_t r;
      logic        down;
      logic [31:0] held;
      logic [31:0] since_rel;
      r         = '0;
      down      = active_low ? !w.button_level : w.button_level;
      held      = w.time_now_ms - press_stamp;
      since_rel = w.time_now_ms - release_stamp;
      case (st)
        bgd_pkg::ST_IDLE: begin
          if (down) begin
            st          = bgd_pkg::ST_PRESSED;
            press_stamp = w.time_now_ms;
          end
        end
        bgd_pkg::ST_PRESSED: begin
          if (down) begin
            if (held > debounce_ms && !press_reported) begin
              press_reported = 1'b1;
              r.press_event  = 1'b1;
            end
            if (held > long_ms && !long_flag) begin
              long_flag          = 1'b1;
              r.long_start_event = 1'b1;
            end
          end else begin
            // bounce: back to idle quietly, flags untouched
            if (held <= debounce_ms) begin
              st = bgd_pkg::ST_IDLE;
            end else begin
              st              = bgd_pkg::ST_RELEASED;
              press_reported  = 1'b0;
              r.release_event = 1'b1;
            end
            release_stamp = w.time_now_ms;
          end
        end
        bgd_pkg::ST_RELEASED: begin
          // new press beats long-end timeout, which beats click timeout
          if (down && since_rel > debounce_ms) begin
            press_stamp = w.time_now_ms;
            st          = bgd_pkg::ST_SECOND;
          end else if (held > long_ms) begin
            long_flag        = 1'b0;
            st               = bgd_pkg::ST_IDLE;
            r.long_end_event = 1'b1;
          end else if (held > click_ms) begin
            st            = bgd_pkg::ST_IDLE;
            r.click_event = 1'b1;
          end
        end
        default: begin
          if (!down && held > debounce_ms) begin
            st                   = bgd_pkg::ST_IDLE;
            r.double_click_event = 1'b1;
          end
        end
      endcase
      r.pressed_now      = (st == bgd_pkg::ST_PRESSED);
      r.long_pressed_now = (st == bgd_pkg::ST_PRESSED) && long_flag;
      expected_q.push_back(r);
    endfunction

    // Compare a result word against the oldest expectation
    function void check_result(bgd_pkg::out_word_t got);
      bgd_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result word %b with nothing expected", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: word %0d expected %b got %b (press rel lstart lend click dbl prs lprs)",
                   checked, want, got);
      end
      checked++;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  bgd_pkg::in_word_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  bgd_pkg::out_word_t out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [bgd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [bgd_pkg::CfgDataW-1:0] cfg_data_i;

  gesture_scoreboard sb = new();

  int unsigned items_sent = 0;
  logic [31:0] now_ms     = '0;
  bit          tx_steady  = 1'b0;
  bit          hold_req   = 1'b0;

  button_gesture_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Monitor both channels at the edge that accepts a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_poll(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // Receiver: random stalls, one long hold-off, one quiet stretch
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          hold_done;
    rx_cycle  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_cycle >= 1200 && rx_cycle < 1800) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 19);
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // Offer one poll word, with random idle cycles ahead of it
  task automatic send_poll(input logic lvl, input logic [31:0] t);
    bgd_pkg::in_word_t w;
    w.button_level = lvl;
    w.time_now_ms  = t;
    tx_steady = (items_sent >= 900 && items_sent < 1200);
    while (!tx_steady && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (items_sent == 700) hold_req = 1'b1;
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // Register write; valid stays up between writes of one batch
  task automatic write_reg(input logic [bgd_pkg::CfgIdxW-1:0] idx,
                           input logic [bgd_pkg::CfgDataW-1:0] val,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // Duration drawn around the current thresholds
  function automatic int unsigned pick_span();
    int unsigned deb;
    int unsigned click_t;
    int unsigned lng;
    deb     = 32'(sb.debounce_ms);
    click_t = 32'(sb.click_ms);
    lng     = 32'(sb.long_ms);
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, deb);
      1: return $urandom_range(deb + 1, (deb + click_t) / 2 + 1);
      2: return $urandom_range(deb, click_t + 1);
      3: return $urandom_range(click_t, lng + 1);
      default: return lng + $urandom_range(1, lng / 2 + 2);
    endcase
  endfunction

  // Hold the button up or down for a span, polling at random steps
  task automatic hold_level(input bit down, input int unsigned span,
                            input int unsigned step_max, input bit chatter);
    int unsigned spent;
    int unsigned dt;
    bit          flip;
    spent = 0;
    do begin
      dt    = $urandom_range(0, step_max);
      flip  = chatter && ($urandom_range(0, 5) == 0);
      now_ms += dt;
      spent += dt;
      send_poll((down ^ flip) ? ~sb.active_low : sb.active_low, now_ms);
    end while (spent < span);
  endtask

  // One gesture: press/release pairs, sometimes with chatter, or pure noise
  task automatic run_gesture();
    int unsigned top;
    int unsigned step_max;
    bit          chatter;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        now_ms = $urandom();
        send_poll(1'($urandom_range(0, 1)), now_ms);
      end
    end else begin
      top = 32'(sb.debounce_ms);
      if (sb.click_ms > top) top = 32'(sb.click_ms);
      if (sb.long_ms > top) top = 32'(sb.long_ms);
      // coarsest step bounded below so one hold stays within about a hundred polls
      step_max = $urandom_range(top / 32 + 1, top / 8 + 1);
      chatter  = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2)) begin
        hold_level(1'b1, pick_span(), step_max, chatter);
        hold_level(1'b0, pick_span(), step_max, chatter);
      end
    end
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned stop;
    stop   = items_sent + n;
    now_ms = $urandom();
    while (items_sent < stop) run_gesture();
    drain();
  endtask

  // Directed polls at reset settings: low level means pressed
  task automatic directed();
    // idle poll, then a long press held past the long-press time
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd100);
    send_poll(1'b0, 32'd150);     // exactly at debounce: no press yet
    send_poll(1'b0, 32'd151);
    send_poll(1'b0, 32'd1101);
    send_poll(1'b0, 32'd1200);
    send_poll(1'b1, 32'd1250);
    send_poll(1'b1, 32'd1300);    // long press ends
    // short bounce
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2030);
    // single click
    send_poll(1'b0, 32'd3000);
    send_poll(1'b0, 32'd3060);
    send_poll(1'b1, 32'd3100);
    send_poll(1'b1, 32'd3401);
    // double click
    send_poll(1'b0, 32'd4000);
    send_poll(1'b0, 32'd4060);
    send_poll(1'b1, 32'd4100);
    send_poll(1'b0, 32'd4151);
    send_poll(1'b1, 32'd4180);
    send_poll(1'b1, 32'd4202);
    // press across the wrap of the timestamp, then a stamp far ahead
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0033);
    send_poll(1'b1, 32'h0000_0040);
    send_poll(1'b1, 32'hFFFF_0000);
    drain();
  endtask

  // Main sequence
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    run_phase(350);

    // high means pressed (set through a masked write), short thresholds
    write_reg(bgd_pkg::CFG_ACTIVE_LOW, 16'hFFFE, 1'b0);
    write_reg(bgd_pkg::CFG_DEBOUNCE_MS, 16'd5, 1'b0);
    write_reg(bgd_pkg::CFG_CLICK_MS, 16'd40, 1'b0);
    write_reg(bgd_pkg::CFG_LONG_PRESS_MS, 16'd100, 1'b0);
    write_reg(8'hFF, 16'h0000, 1'b1);
    run_phase(350);

    // all thresholds zero
    write_reg(bgd_pkg::CFG_ACTIVE_LOW, 16'h0001, 1'b0);
    write_reg(bgd_pkg::CFG_DEBOUNCE_MS, 16'h0000, 1'b0);
    write_reg(bgd_pkg::CFG_CLICK_MS, 16'h0000, 1'b0);
    write_reg(bgd_pkg::CFG_LONG_PRESS_MS, 16'h0000, 1'b0);
    write_reg(8'd4, 16'hFFFF, 1'b1);
    run_phase(350);

    // all thresholds at maximum
    write_reg(bgd_pkg::CFG_ACTIVE_LOW, 16'h0000, 1'b0);
    write_reg(bgd_pkg::CFG_DEBOUNCE_MS, 16'hFFFF, 1'b0);
    write_reg(bgd_pkg::CFG_CLICK_MS, 16'hFFFF, 1'b0);
    write_reg(bgd_pkg::CFG_LONG_PRESS_MS, 16'hFFFF, 1'b1);
    run_phase(350);

    // random settings
    write_reg(bgd_pkg::CFG_ACTIVE_LOW, 16'($urandom()), 1'b0);
    write_reg(bgd_pkg::CFG_DEBOUNCE_MS, 16'($urandom_range(0, 65535)), 1'b0);
    write_reg(bgd_pkg::CFG_CLICK_MS, 16'($urandom_range(0, 3000)), 1'b0);
    write_reg(bgd_pkg::CFG_LONG_PRESS_MS, 16'($urandom_range(0, 3000)), 1'b1);
    run_phase(350);

    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### button_gesture_detector.f
rtl/bgd_pkg.sv
rtl/button_gesture_detector.sv
sim/tb_button_gesture_detector.sv
